@@ hdl/mvtp_pkg.sv @@
// Shared constants, types and length tables for the MIDI volume tracking parser.
// No dependencies; imported by the parser and its port checker.
package mvtp_pkg;

    localparam int BUFFER_LIMIT = 256;
    localparam int NUM_CHANNELS = 16;
    localparam int HEAD_DEPTH   = 8;

    localparam int IDX_W  = $clog2(BUFFER_LIMIT + 1);
    localparam int HEAD_W = $clog2(HEAD_DEPTH);
    localparam int CH_W   = $clog2(NUM_CHANNELS);
    localparam int VOL_W  = 7;
    localparam int LEN_W  = 2;

    typedef logic [7:0]       t_byte;
    typedef logic [VOL_W-1:0] t_vol;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [LEN_W-1:0] t_len;

    // Configuration register indexes
    localparam logic CFG_EDU_ID   = 1'b0;
    localparam logic CFG_DUMP_END = 1'b1;

    localparam t_byte RT_FIRST    = 8'hF8;
    localparam t_byte SX_START    = 8'hF0;
    localparam t_byte SX_END      = 8'hF7;
    localparam t_byte SX_TYPE_RT  = 8'h7F;
    localparam t_byte SX_TYPE_EDU = 8'h7D;
    localparam t_byte SX_CONTROL  = 8'h04;
    localparam t_byte SX_MASTER   = 8'h01;
    localparam t_byte CTL_VOLUME  = 8'h07;
    localparam logic [3:0] CTL_NIBBLE = 4'hB;
    localparam logic [3:0] SYS_NIBBLE = 4'hF;

    localparam t_idx SX_MIN_LEN    = t_idx'(6);
    localparam t_idx SX_MASTER_LEN = t_idx'(8);
    localparam t_idx LIMIT_IDX     = t_idx'(BUFFER_LIMIT);

    // Expected length of a channel voice message, by status bits [6:4]
    function automatic t_len chan_msg_length(input logic [2:0] code);
        t_len len;
        case (code)
            3'd4, 3'd5: len = 2'd2;
            3'd7:       len = 2'd0;
            default:    len = 2'd3;
        endcase
        return len;
    endfunction

    // Expected length of a system common message, by status bits [2:0]
    function automatic t_len sys_msg_length(input logic [2:0] code);
        t_len len;
        case (code)
            3'd1, 3'd3: len = 2'd2;
            3'd2:       len = 2'd3;
            3'd6, 3'd7: len = 2'd1;
            default:    len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/midi_volume_tracking_parser.sv @@
// MIDI volume tracking parser: running-status decode, per-channel volume table,
// master volume and dump-end sysex detection. Depends on mvtp_pkg.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | into      | i_in_valid / o_in_stall    | i_data_byte, i_read_channel
//  out     | out of    | o_out_valid / i_out_stall  | o_vol_*, o_master_*, o_dump_done,
//          |           |                            | o_read_volume
//  cfg     | into      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One word in and one word out: the byte is decoded in a single
// pass of logic against the parser state and the result lands in the output register
// at the accepting edge. Sustained rate is one word per cycle; the output register
// is the only buffering, so the input stalls exactly when that register is full and
// the downstream stalls. Synchronous active-low reset clears the parser state, the
// volume table and the configuration registers; the message head buffer has no reset.
module midi_volume_tracking_parser
    import mvtp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input words
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_data_byte,
    input  logic [CH_W-1:0] i_read_channel,
    // result words
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_vol_valid,
    output logic [CH_W-1:0] o_vol_channel,
    output logic [6:0]      o_vol_value,
    output logic            o_master_valid,
    output logic [6:0]      o_master_value,
    output logic            o_master_known,
    output logic            o_dump_done,
    output logic [6:0]      o_read_volume,
    // configuration
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [6:0]      i_cfg_data
);

    // ---------------- state ----------------
    t_byte r_status, n_status;
    t_idx  r_idx,    n_idx;
    t_len  r_exp,    n_exp;
    t_byte r_head [HEAD_DEPTH];
    t_byte n_head [HEAD_DEPTH];
    t_vol  r_vol  [NUM_CHANNELS];
    t_vol  n_vol  [NUM_CHANNELS];
    t_vol  r_master, n_master;
    logic  r_master_seen, n_master_seen;
    logic  r_dump, n_dump;
    t_vol  r_edu_id, r_dump_end;

    // output register
    logic            r_out_valid;
    logic            r_vol_valid, n_vol_valid;
    logic [CH_W-1:0] r_vol_ch,    n_vol_ch;
    t_vol            r_vol_val,   n_vol_val;
    logic            r_mst_valid, n_mst_valid;
    t_vol            r_rd_vol;

    logic  accept;
    logic  sx_check;
    t_idx  pos;
    t_byte c;

    // Output register frees itself in the same cycle it is taken.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign c          = i_data_byte;

    // ---------------- byte decode ----------------
    always_comb begin
        n_status      = r_status;
        n_idx         = r_idx;
        n_exp         = r_exp;
        n_head        = r_head;
        n_vol         = r_vol;
        n_master      = r_master;
        n_master_seen = r_master_seen;
        n_dump        = r_dump;
        n_vol_valid   = 1'b0;
        n_vol_ch      = '0;
        n_vol_val     = '0;
        n_mst_valid   = 1'b0;
        sx_check      = 1'b0;
        pos           = r_idx;

        if (c >= RT_FIRST) begin
            // real-time byte: drop
        end else if (c[7:4] == SYS_NIBBLE) begin
            if (r_status == SX_START && c == SX_END && r_idx < LIMIT_IDX) begin
                // sysex end: append and decode with the new length
                if (r_idx < t_idx'(HEAD_DEPTH)) begin
                    n_head[r_idx[HEAD_W-1:0]] = c;
                end
                n_idx    = r_idx + t_idx'(1);
                sx_check = 1'b1;
            end else begin
                n_head[0] = c;
                n_exp     = sys_msg_length(c[2:0]);
                n_status  = c;
                n_idx     = t_idx'(1);
            end
        end else if (c[7]) begin
            n_head[0] = c;
            n_exp     = chan_msg_length(c[6:4]);
            n_status  = c;
            n_idx     = t_idx'(1);
        end else if (r_status != '0 && r_idx < LIMIT_IDX) begin
            // data byte; at index zero re-insert the running status first
            if (r_idx == '0) begin
                n_head[0] = r_status;
                pos       = t_idx'(1);
            end
            if (pos < t_idx'(HEAD_DEPTH)) begin
                n_head[pos[HEAD_W-1:0]] = c;
            end
            n_idx = pos + t_idx'(1);
            if (n_idx == t_idx'(r_exp)) begin
                if (n_head[0][7:4] == CTL_NIBBLE && n_head[1] == CTL_VOLUME) begin
                    n_vol_valid        = 1'b1;
                    n_vol_ch           = n_head[0][CH_W-1:0];
                    n_vol_val          = n_head[2][6:0];
                    n_vol[n_vol_ch]    = n_head[2][6:0];
                end
                n_idx = '0;
            end
        end

        // sysex content, decoded from the head as it stands after this byte
        if (sx_check && n_idx >= SX_MIN_LEN) begin
            if (n_head[1] == SX_TYPE_RT && n_head[3] == SX_CONTROL
                    && n_head[4] == SX_MASTER) begin
                if (n_idx == SX_MASTER_LEN) begin
                    n_master      = n_head[6][6:0];
                    n_master_seen = 1'b1;
                    n_mst_valid   = 1'b1;
                end
            end else if (n_head[1] == SX_TYPE_EDU && n_head[3] == {1'b0, r_edu_id}
                    && n_head[4] == {1'b0, r_dump_end}) begin
                n_dump = 1'b1;
            end
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status      <= '0;
            r_idx         <= '0;
            r_exp         <= '0;
            r_master      <= '0;
            r_master_seen <= 1'b0;
            r_dump        <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_vol[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_status      <= n_status;
                r_idx         <= n_idx;
                r_exp         <= n_exp;
                r_master      <= n_master;
                r_master_seen <= n_master_seen;
                r_dump        <= n_dump;
                r_vol         <= n_vol;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edu_id   <= '0;
            r_dump_end <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EDU_ID:   r_edu_id   <= i_cfg_data;
                CFG_DUMP_END: r_dump_end <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // ---------------- payload: head buffer and result word ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head      <= n_head;
            r_vol_valid <= n_vol_valid;
            r_vol_ch    <= n_vol_ch;
            r_vol_val   <= n_vol_val;
            r_mst_valid <= n_mst_valid;
            r_rd_vol    <= n_vol[i_read_channel];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_vol_valid    = r_vol_valid;
    assign o_vol_channel  = r_vol_ch;
    assign o_vol_value    = r_vol_val;
    assign o_master_valid = r_mst_valid;
    assign o_master_value = r_master;
    assign o_master_known = r_master_seen;
    assign o_dump_done    = r_dump;
    assign o_read_volume  = r_rd_vol;

endmodule

@@ hdl/mvtp_port_checker.sv @@
// Port-level checks for the MIDI volume tracking parser, attached by bind.
// Depends on mvtp_pkg and midi_volume_tracking_parser.
module mvtp_port_checker
    import mvtp_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input logic            o_vol_valid,
    input logic [CH_W-1:0] o_vol_channel,
    input logic [6:0]      o_vol_value,
    input logic            o_master_valid,
    input logic            o_master_known,
    input logic            o_dump_done
);

    // input stalls only while a result word waits
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    // accepted word shows up on the next cycle
    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted word produced no result");

    // held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_vol_value)
            && $stable(o_vol_channel) && $stable(o_dump_done))
        else $error("stalled result changed");

    // no volume event: channel and value read zero
    a_vol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_vol_valid |-> o_vol_channel == '0 && o_vol_value == '0)
        else $error("volume fields set without a volume event");

    // a master update implies the master is known
    a_master_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_master_valid |-> o_master_known)
        else $error("master update without master_known");

endmodule

bind midi_volume_tracking_parser mvtp_port_checker u_mvtp_port_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_vol_valid    (o_vol_valid),
    .o_vol_channel  (o_vol_channel),
    .o_vol_value    (o_vol_value),
    .o_master_valid (o_master_valid),
    .o_master_known (o_master_known),
    .o_dump_done    (o_dump_done)
);

@@ verif/testbench.sv @@
// Self-checking testbench for midi_volume_tracking_parser: streams MIDI bytes, predicts
// every result word and compares it field by field. Depends on mvtp_pkg and the parser RTL.
`timescale 1ns / 100ps

module testbench;
    import mvtp_pkg::*;

    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 240;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 8;
    localparam t_vol DIRECTED_EDU_ID   = 7'h55;
    localparam t_vol DIRECTED_DUMP_END = 7'h2A;

    typedef struct {
        t_byte           data;
        logic [CH_W-1:0] chan;
    } t_midi_word;

    typedef struct {
        logic            vol_valid;
        logic [CH_W-1:0] vol_channel;
        t_vol            vol_value;
        logic            master_valid;
        t_vol            master_value;
        logic            master_known;
        logic            dump_done;
        t_vol            read_volume;
    } t_parser_report;

    // DUT ports; every input starts at a known value
    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            i_in_valid     = 1'b0;
    logic            o_in_stall;
    logic [7:0]      i_data_byte    = 8'h00;
    logic [CH_W-1:0] i_read_channel = '0;
    logic            o_out_valid;
    logic            i_out_stall    = 1'b0;
    logic            o_vol_valid;
    logic [CH_W-1:0] o_vol_channel;
    logic [6:0]      o_vol_value;
    logic            o_master_valid;
    logic [6:0]      o_master_value;
    logic            o_master_known;
    logic            o_dump_done;
    logic [6:0]      o_read_volume;
    logic            i_cfg_we       = 1'b0;
    logic            i_cfg_index    = CFG_EDU_ID;
    logic [6:0]      i_cfg_data     = 7'h00;

    // Word streams: bytes waiting to go in, predicted results waiting to come out
    t_midi_word     midi_bytes[$];
    t_parser_report parser_reports[$];

    // Shadow of the parser state and its two registers
    t_byte run_status   = '0;
    t_idx  msg_pos      = '0;
    t_len  msg_len      = '0;
    t_byte head_bytes [HEAD_DEPTH];
    t_vol  chan_volume [NUM_CHANNELS];
    t_vol  master_level = '0;
    logic  master_seen  = 1'b0;
    logic  dump_seen    = 1'b0;
    t_vol  edu_id_reg   = '0;
    t_vol  dump_end_reg = '0;

    // Expected message length by status bits, voice [6:4] and system common [2:0]
    t_len chan_length_tab [8] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd0};
    t_len sys_length_tab  [8] = '{2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};

    int unsigned send_gap_pct  = 0;
    int unsigned out_stall_pct = 0;
    int unsigned phase_words;
    int unsigned words_sent     = 0;
    int unsigned reports_seen   = 0;
    int unsigned vol_updates    = 0;
    int unsigned master_updates = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    t_midi_word     cur_word;
    t_midi_word     seed_word;
    t_parser_report predicted;
    t_parser_report oldest;
    t_byte          directed_bytes[];

    midi_volume_tracking_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_read_channel (i_read_channel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_vol_valid    (o_vol_valid),
        .o_vol_channel  (o_vol_channel),
        .o_vol_value    (o_vol_value),
        .o_master_valid (o_master_valid),
        .o_master_value (o_master_value),
        .o_master_known (o_master_known),
        .o_dump_done    (o_dump_done),
        .o_read_volume  (o_read_volume),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_CHANNELS; i++)
            chan_volume[i] = '0;
        for (int i = 0; i < HEAD_DEPTH; i++)
            head_bytes[i] = '0;
    end

    // Store a byte of the current message; only the first HEAD_DEPTH are kept
    function automatic void put_head(input t_idx pos, input t_byte value);
        if (pos < t_idx'(HEAD_DEPTH))
            head_bytes[pos[HEAD_W-1:0]] = value;
    endfunction

    // Advance the shadow parser by one byte and return the result word it causes
    function automatic t_parser_report track_midi_byte(input t_byte b,
                                                       input logic [CH_W-1:0] rd);
        t_parser_report r;
        t_byte          status;
        r.vol_valid    = 1'b0;
        r.vol_channel  = '0;
        r.vol_value    = '0;
        r.master_valid = 1'b0;
        if (b >= RT_FIRST) begin
            // real-time bytes leave the parser untouched
        end else if (b >= SX_START) begin
            if (run_status == SX_START && b == SX_END && msg_pos < LIMIT_IDX) begin
                // end of sysex (possibly repeated): append, then decode the head
                put_head(msg_pos, b);
                msg_pos++;
                if (msg_pos >= SX_MIN_LEN) begin
                    if (head_bytes[1] == SX_TYPE_RT && head_bytes[3] == SX_CONTROL &&
                        head_bytes[4] == SX_MASTER) begin
                        if (msg_pos == SX_MASTER_LEN) begin
                            master_level   = head_bytes[6][6:0];
                            master_seen    = 1'b1;
                            r.master_valid = 1'b1;
                        end
                    end else if (head_bytes[1] == SX_TYPE_EDU &&
                                 head_bytes[3] == {1'b0, edu_id_reg} &&
                                 head_bytes[4] == {1'b0, dump_end_reg}) begin
                        dump_seen = 1'b1;
                    end
                end
            end else begin
                put_head('0, b);
                msg_len    = sys_length_tab[b[2:0]];
                run_status = b;
                msg_pos    = t_idx'(1);
            end
        end else if (b[7]) begin
            put_head('0, b);
            msg_len    = chan_length_tab[b[6:4]];
            run_status = b;
            msg_pos    = t_idx'(1);
        end else if (run_status != '0 && msg_pos < LIMIT_IDX) begin
            if (msg_pos == '0) begin
                // running status: the status byte heads the new message
                head_bytes[0] = run_status;
                msg_pos       = t_idx'(1);
            end
            put_head(msg_pos, b);
            msg_pos++;
            if (msg_pos == t_idx'(msg_len)) begin
                status = head_bytes[0];
                if (status[7:4] == CTL_NIBBLE && head_bytes[1] == CTL_VOLUME) begin
                    r.vol_valid  = 1'b1;
                    r.vol_channel = status[CH_W-1:0];
                    r.vol_value  = head_bytes[2][6:0];
                    chan_volume[status[CH_W-1:0]] = head_bytes[2][6:0];
                end
                msg_pos = '0;
            end
        end
        r.master_value = master_level;
        r.master_known = master_seen;
        r.dump_done    = dump_seen;
        r.read_volume  = chan_volume[rd];
        return r;
    endfunction

    // Driver: hold a word while stalled, advance on acceptance, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted = track_midi_byte(cur_word.data, cur_word.chan);
                parser_reports.push_back(predicted);
                words_sent++;
                if (predicted.vol_valid)
                    vol_updates++;
                if (predicted.master_valid)
                    master_updates++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (midi_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    cur_word = midi_bytes.pop_front();
                    i_in_valid     <= 1'b1;
                    i_data_byte    <= cur_word.data;
                    i_read_channel <= cur_word.chan;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Monitor: random back-pressure, compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
            if (o_out_valid && !i_out_stall) begin
                reports_seen++;
                if (parser_reports.size() == 0) begin
                    $display("%0t: extra result word, expected none, actual vol %0d/%0d/%0d",
                             $time, o_vol_valid, o_vol_channel, o_vol_value);
                    error_count++;
                end else begin
                    oldest = parser_reports.pop_front();
                    check_field("vol_valid",    oldest.vol_valid,    o_vol_valid);
                    check_field("vol_channel",  oldest.vol_channel,  o_vol_channel);
                    check_field("vol_value",    oldest.vol_value,    o_vol_value);
                    check_field("master_valid", oldest.master_valid, o_master_valid);
                    check_field("master_value", oldest.master_value, o_master_value);
                    check_field("master_known", oldest.master_known, o_master_known);
                    check_field("dump_done",    oldest.dump_done,    o_dump_done);
                    check_field("read_volume",  oldest.read_volume,  o_read_volume);
                end
            end
        end
    end

    // Hold until every queued byte went in and every predicted word came out
    task automatic wait_drain();
        @(negedge i_clk);
        while (midi_bytes.size() != 0 || i_in_valid || parser_reports.size() != 0)
            @(negedge i_clk);
    endtask

    // Only called while the parser is idle
    task automatic write_register(input logic index, input t_vol value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index == CFG_EDU_ID)
            edu_id_reg = value;
        else
            dump_end_reg = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_byte data7();
        return t_byte'($urandom_range(127));
    endfunction

    // Queue one byte, sometimes preceded by a stray real-time byte
    task automatic add_byte(input t_byte b);
        t_midi_word w;
        if ($urandom_range(19) == 0) begin
            w.data = RT_FIRST + t_byte'($urandom_range(7));
            w.chan = CH_W'($urandom_range(NUM_CHANNELS - 1));
            midi_bytes.push_back(w);
        end
        w.data = b;
        w.chan = CH_W'($urandom_range(NUM_CHANNELS - 1));
        midi_bytes.push_back(w);
        if (b < RT_FIRST)
            phase_words++;
    endtask

    // Sysex long enough to reach the buffer bound, so the closing F7 may start a new message
    task automatic add_long_sysex();
        add_byte(SX_START);
        repeat ($urandom_range(253, 262))
            add_byte(data7());
        add_byte(SX_END);
    endtask

    // One random message: mostly well-formed, with broken variants and noise
    task automatic add_message();
        int unsigned     kind;
        int unsigned     n;
        int unsigned     variant;
        logic [CH_W-1:0] ch;
        logic [2:0]      code;
        kind = $urandom_range(99);
        ch   = CH_W'($urandom_range(NUM_CHANNELS - 1));
        if (kind < 30) begin
            // volume change, leaning on running status a third of the time
            if ($urandom_range(2) != 0)
                add_byte({CTL_NIBBLE, ch});
            add_byte(CTL_VOLUME);
            add_byte(data7());
        end else if (kind < 45) begin
            // any other voice message
            code = 3'($urandom_range(6));
            add_byte({1'b1, code, ch});
            n = (code == 3'd4 || code == 3'd5) ? 1 : 2;
            if ($urandom_range(7) == 0)
                n++;
            repeat (n)
                add_byte(data7());
        end else if (kind < 60) begin
            // master volume: short, long, corrupt and repeated-end variants
            variant = $urandom_range(9);
            add_byte(SX_START);
            add_byte(SX_TYPE_RT);
            add_byte(data7());
            add_byte(variant == 4 ? data7() : SX_CONTROL);
            add_byte(SX_MASTER);
            add_byte(data7());
            if (variant != 0 && variant != 2)
                add_byte(data7());
            if (variant == 1)
                add_byte(data7());
            add_byte(SX_END);
            if (variant == 2 || variant == 3)
                add_byte(SX_END);
        end else if (kind < 72) begin
            // educational sysex, ids matching the registers half the time each
            add_byte(SX_START);
            add_byte(SX_TYPE_EDU);
            add_byte(data7());
            add_byte($urandom_range(1) ? {1'b0, edu_id_reg} : data7());
            if ($urandom_range(5) != 0)
                add_byte($urandom_range(1) ? {1'b0, dump_end_reg} : data7());
            repeat ($urandom_range(3))
                add_byte(data7());
            add_byte(SX_END);
        end else if (kind < 80) begin
            // system common, including the lengths that never complete
            add_byte({SYS_NIBBLE, 4'($urandom_range(1, 7))});
            repeat ($urandom_range(3))
                add_byte(data7());
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 4))
                add_byte(t_byte'($urandom_range(255)));
        end else begin
            add_byte(SX_START);
            repeat ($urandom_range(10))
                add_byte(data7());
            add_byte(SX_END);
            if ($urandom_range(3) == 0)
                add_byte(SX_END);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: data before any status, real-time extremes, volume with and without
        // running status, a full master sysex and a matching dump-end sysex
        write_register(CFG_EDU_ID, DIRECTED_EDU_ID);
        write_register(CFG_DUMP_END, DIRECTED_DUMP_END);
        directed_bytes = '{8'h00, 8'h7F, RT_FIRST, 8'hFF,
                           {CTL_NIBBLE, 4'h3}, CTL_VOLUME, 8'h7F,
                           CTL_VOLUME, 8'h00,
                           {CTL_NIBBLE, 4'hF}, CTL_VOLUME, 8'h40,
                           SX_START, SX_TYPE_RT, 8'h01, SX_CONTROL, SX_MASTER,
                           8'h00, 8'h7F, SX_END,
                           SX_START, SX_TYPE_EDU, 8'h00, {1'b0, DIRECTED_EDU_ID},
                           {1'b0, DIRECTED_DUMP_END}, SX_END};
        @(negedge i_clk);
        foreach (directed_bytes[i]) begin
            seed_word.data = directed_bytes[i];
            seed_word.chan = i[0] ? '1 : '0;
            midi_bytes.push_back(seed_word);
        end
        // the sender stays quiet here until every result is back
        wait_drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_register(CFG_EDU_ID, 7'h00);
                    write_register(CFG_DUMP_END, 7'h00);
                end
                1: begin
                    write_register(CFG_EDU_ID, 7'h7F);
                    write_register(CFG_DUMP_END, 7'h7F);
                end
                2: begin
                    write_register(CFG_EDU_ID, 7'h00);
                    write_register(CFG_DUMP_END, 7'h7F);
                end
                default: begin
                    write_register(CFG_EDU_ID, t_vol'($urandom_range(127)));
                    write_register(CFG_DUMP_END, t_vol'($urandom_range(127)));
                end
            endcase
            @(negedge i_clk);
            case (p % 4)
                0:       begin send_gap_pct = 0;  out_stall_pct = 0;  end
                1:       begin send_gap_pct = 50; out_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  out_stall_pct = 50; end
                default: begin send_gap_pct = 12; out_stall_pct = 12; end
            endcase
            phase_words = 0;
            if (p == 2 || p == 5)
                add_long_sysex();
            while (phase_words < WORDS_PER_PHASE)
                add_message();
            wait_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes over %0d register settings and four idling modes;",
                 words_sent, PHASES + 1);
        $display("checked %0d result words, %0d volume updates, %0d master volume updates.",
                 reports_seen, vol_updates, master_updates);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
